/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

/* design/lcadc_pkg.sv */
// ---------------------------------------------------------------------------
// lcadc_pkg
// shared types and constants of the load cell converter reader
// ---------------------------------------------------------------------------
package lcadc_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int BIT_CNT_W   = 5;
    localparam int SUM_W       = 31;
    localparam int THRESH_W    = 32;
    localparam int GAIN_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int DELTA_W     = SAMPLE_W + 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PULSES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_BIT_HIGH  = 5'b00010,
        PH_BIT_LOW   = 5'b00100,
        PH_GAIN_HIGH = 5'b01000,
        PH_GAIN_LOW  = 5'b10000
    } t_phase;

    // strobes from the serial sequencer to the filter
    typedef struct packed {
        logic                load_delta;
        logic                finish;
        logic [SAMPLE_W-1:0] sample;
    } t_filt_ctrl;

    // filter state as it stands after the current item
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    indicator;
    } t_filt_stat;

endpackage

/* design/lcadc_filter.sv */
// ---------------------------------------------------------------------------
// lcadc_filter
// moving-sum ring in a synchronous memory with threshold compare
// ---------------------------------------------------------------------------
module lcadc_filter #(
    parameter int FILTER_SHIFT = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  lcadc_pkg::t_filt_ctrl                  i_ctrl,
    input  logic signed [lcadc_pkg::THRESH_W-1:0]  i_threshold,
    output lcadc_pkg::t_filt_stat                  o_stat
);

    localparam int RING_DEPTH = 1 << FILTER_SHIFT;
    localparam int PTR_W      = (FILTER_SHIFT > 0) ? FILTER_SHIFT : 1;

    logic [lcadc_pkg::SAMPLE_W-1:0]        r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0]                 r_ring_vld;
    logic [PTR_W-1:0]                      r_ptr;
    logic [lcadc_pkg::SAMPLE_W-1:0]        r_rd_data;
    logic                                  r_rd_vld;
    logic signed [lcadc_pkg::DELTA_W-1:0]  r_delta;
    logic signed [lcadc_pkg::SUM_W-1:0]    r_sum;
    logic                                  r_ind;

    logic [lcadc_pkg::SAMPLE_W-1:0]        old_val;
    logic signed [lcadc_pkg::SUM_W-1:0]    n_sum;
    logic                                  n_ind;
    logic [PTR_W-1:0]                      n_ptr;

    // ring memory: one write port at the ring pointer, registered read of the
    // same entry every cycle; a whole read lies between one finish and the next
    // delta, so the read data is always fresh by the time the delta is formed
    always_ff @(posedge i_clk) begin
        if (i_ctrl.finish) begin
            r_ring[r_ptr] <= i_ctrl.sample;
        end
        r_rd_data <= r_ring[r_ptr];
    end

    // never-written entries read as zero
    assign old_val = r_rd_vld ? r_rd_data : '0;

    assign n_sum = r_sum + {{(lcadc_pkg::SUM_W - lcadc_pkg::DELTA_W){r_delta[lcadc_pkg::DELTA_W-1]}},
                            r_delta};
    assign n_ind = $signed({n_sum[lcadc_pkg::SUM_W-1], n_sum}) > i_threshold;
    assign n_ptr = (r_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : r_ptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
            r_rd_vld   <= 1'b0;
            r_ptr      <= '0;
            r_sum      <= '0;
            r_ind      <= 1'b0;
        end else begin
            r_rd_vld <= r_ring_vld[r_ptr];
            if (i_ctrl.finish) begin
                r_ring_vld[r_ptr] <= 1'b1;
                r_ptr             <= n_ptr;
                r_sum             <= n_sum;
                r_ind             <= n_ind;
            end
        end
    end

    // new minus oldest, formed during a gain pulse once the shift is complete
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_delta) begin
            r_delta <= $signed({i_ctrl.sample[lcadc_pkg::SAMPLE_W-1], i_ctrl.sample})
                     - $signed({old_val[lcadc_pkg::SAMPLE_W-1], old_val});
        end
    end

    assign o_stat.sum       = i_ctrl.finish ? n_sum : r_sum;
    assign o_stat.indicator = i_ctrl.finish ? n_ind : r_ind;

endmodule

/* design/load_cell_adc_reader_threshold.sv */
// ---------------------------------------------------------------------------
// load_cell_adc_reader_threshold
// two-wire 24-bit converter reader with moving-sum threshold indicator
// ---------------------------------------------------------------------------
// each input item is one tick of the serial interface carrying the sampled
// data line level; each item gives exactly one result item with the clock
// level to drive for that tick, busy and sample-complete flags, the last
// sample, the ring sum and the held indicator.
// an item is taken every cycle unless stalled: its result is loaded into an
// output register as the item is accepted, and a new item is accepted in the
// same cycle as the waiting result is taken. while the result receiver stalls
// and the output register is full, o_stall is raised towards the sender.
// a read takes 1 start tick, 47 bit ticks and 2 ticks per gain pulse; the
// sum update uses a delta formed during the gain pulses from the ring
// memory's registered read, so the sample is folded in with one add.
// reset (synchronous, active low) returns to idle with gain pulses 1,
// threshold 0, a zero sum and all ring entries reading as zero through
// per-entry valid bits; no clearing pass is needed.
// configuration writes take effect at the next edge.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module load_cell_adc_reader_threshold #(
    parameter int FILTER_SHIFT = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_wr_en,
    input  logic [lcadc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lcadc_pkg::THRESH_W-1:0]         i_cfg_data,
    // tick input
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_dout_level,
    // result output
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_sck,
    output logic                                   o_busy_res,
    output logic                                   o_sample_valid,
    output logic signed [lcadc_pkg::SAMPLE_W-1:0]  o_raw_sample,
    output logic signed [lcadc_pkg::SUM_W-1:0]     o_filtered_sum,
    output logic                                   o_indicator_active
);

    lcadc_pkg::t_phase                     r_phase, n_phase;
    logic [lcadc_pkg::BIT_CNT_W-1:0]       r_bit_count, n_bit_count;
    logic [lcadc_pkg::SAMPLE_W-1:0]        r_shift, n_shift;
    logic [lcadc_pkg::GAIN_W-1:0]          r_pulse_count, n_pulse_count;
    logic [lcadc_pkg::SAMPLE_W-1:0]        r_last_sample, n_last_sample;
    logic [lcadc_pkg::GAIN_W-1:0]          r_gain_pulses;
    logic signed [lcadc_pkg::THRESH_W-1:0] r_threshold;
    logic                                  r_out_valid;

    logic                                  in_acc;
    logic                                  step_sck;
    logic                                  step_busy;
    logic                                  step_finish;
    logic                                  step_load_delta;
    logic [lcadc_pkg::GAIN_W-1:0]          need_pulses;
    lcadc_pkg::t_filt_ctrl                 filt_ctrl;
    lcadc_pkg::t_filt_stat                 filt_stat;

    assign o_stall = r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;

    // a gain count of zero behaves as one pulse
    assign need_pulses = (r_gain_pulses == '0) ? lcadc_pkg::GAIN_W'(1) : r_gain_pulses;

    always_comb begin
        n_phase         = r_phase;
        n_bit_count     = r_bit_count;
        n_shift         = r_shift;
        n_pulse_count   = r_pulse_count;
        step_sck        = 1'b0;
        step_busy       = 1'b1;
        step_finish     = 1'b0;
        step_load_delta = 1'b0;
        case (r_phase)
            lcadc_pkg::PH_BIT_HIGH: begin
                step_sck = 1'b1;
                n_phase  = lcadc_pkg::PH_BIT_LOW;
            end
            lcadc_pkg::PH_BIT_LOW: begin
                n_shift     = {r_shift[lcadc_pkg::SAMPLE_W-2:0], i_dout_level};
                n_bit_count = r_bit_count + lcadc_pkg::BIT_CNT_W'(1);
                if (n_bit_count >= lcadc_pkg::BIT_CNT_W'(lcadc_pkg::SAMPLE_W)) begin
                    n_pulse_count = '0;
                    n_phase       = lcadc_pkg::PH_GAIN_HIGH;
                end else begin
                    n_phase = lcadc_pkg::PH_BIT_HIGH;
                end
            end
            lcadc_pkg::PH_GAIN_HIGH: begin
                step_sck        = 1'b1;
                step_load_delta = 1'b1;
                n_phase         = lcadc_pkg::PH_GAIN_LOW;
            end
            lcadc_pkg::PH_GAIN_LOW: begin
                n_pulse_count = r_pulse_count + lcadc_pkg::GAIN_W'(1);
                if (n_pulse_count == '0 || n_pulse_count >= need_pulses) begin
                    step_finish = 1'b1;
                    n_phase     = lcadc_pkg::PH_IDLE;
                end else begin
                    n_phase = lcadc_pkg::PH_GAIN_HIGH;
                end
            end
            default: begin
                n_phase = lcadc_pkg::PH_IDLE;
                // the starting tick already drives the first clock high
                if (!i_dout_level) begin
                    step_sck      = 1'b1;
                    n_bit_count   = '0;
                    n_shift       = '0;
                    n_pulse_count = '0;
                    n_phase       = lcadc_pkg::PH_BIT_LOW;
                end else begin
                    step_busy = 1'b0;
                end
            end
        endcase
    end

    assign n_last_sample = step_finish ? r_shift : r_last_sample;

    assign filt_ctrl.load_delta = in_acc && step_load_delta;
    assign filt_ctrl.finish     = in_acc && step_finish;
    assign filt_ctrl.sample     = r_shift;

    lcadc_filter #(
        .FILTER_SHIFT (FILTER_SHIFT)
    ) u_filter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (filt_ctrl),
        .i_threshold (r_threshold),
        .o_stat      (filt_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= lcadc_pkg::PH_IDLE;
            r_bit_count   <= '0;
            r_shift       <= '0;
            r_pulse_count <= '0;
            r_last_sample <= '0;
            r_gain_pulses <= lcadc_pkg::GAIN_W'(1);
            r_threshold   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase       <= n_phase;
                r_bit_count   <= n_bit_count;
                r_shift       <= n_shift;
                r_pulse_count <= n_pulse_count;
                r_last_sample <= n_last_sample;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    lcadc_pkg::REG_GAIN_PULSES:
                        r_gain_pulses <= i_cfg_data[lcadc_pkg::GAIN_W-1:0];
                    lcadc_pkg::REG_THRESHOLD:
                        r_threshold <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register, loaded whenever an item is accepted
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            o_sck              <= step_sck;
            o_busy_res         <= step_busy;
            o_sample_valid     <= step_finish;
            o_raw_sample       <= $signed(n_last_sample);
            o_filtered_sum     <= filt_stat.sum;
            o_indicator_active <= filt_stat.indicator;
        end
    end

    assign o_valid = r_out_valid;

    `ASSERT_CLK(a_sample_in_read, i_clk, i_rst_n, (o_valid && o_sample_valid) |-> o_busy_res, "sample completed outside a read")
    `ASSERT_CLK(a_sck_in_read, i_clk, i_rst_n, (o_valid && !o_busy_res) |-> !o_sck, "clock driven high while not busy")
    `ASSERT_NEVER(a_bit_count_range, i_clk, i_rst_n, r_bit_count > lcadc_pkg::BIT_CNT_W'(lcadc_pkg::SAMPLE_W), "bit count past sample width")

endmodule
